// ----- rtl/core/aes_cbc_pkg.sv -----
// Package: types, constants and round functions for the AES-128 CBC cipher.
package aes_cbc_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  valid_bytes;
        logic        final_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_bytes;
        logic        out_last;
        logic        status;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEYEXP,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } t_state;

    localparam logic [2:0] REG_KEY_HIGH  = 3'd0;
    localparam logic [2:0] REG_KEY_LOW   = 3'd1;
    localparam logic [2:0] REG_IV_HIGH   = 3'd2;
    localparam logic [2:0] REG_IV_LOW    = 3'd3;
    localparam logic [2:0] REG_DIRECTION = 3'd4;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned NumKeyWords = 44;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
        logic [7:0] a0, a1, a2, a3, u, v;
        logic [7:0] b0, b1, b2, b3;
        a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
        if (inv) begin
            u = xt(xt(a0 ^ a2));
            v = xt(xt(a1 ^ a3));
            a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
        end
        b0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        b1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        b2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        b3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        return {b0, b1, b2, b3};
    endfunction

endpackage

// ----- rtl/core/aes_cbc_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module aes_cbc_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 44
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/aes_cbc_round.sv -----
// Shared AES round unit: one forward or inverse round on a 128-bit state.
module aes_cbc_round (
    input  logic [127:0] i_state,
    input  logic [127:0] i_rkey,
    input  logic         i_inv,
    input  logic         i_mix,
    output logic [127:0] o_state
);
    logic [7:0]   w_b [16];
    logic [7:0]   w_s [16];
    logic [127:0] w_sh;
    logic [127:0] w_mx;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_b[i] = i_state[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_s[4*c+r] = i_inv ? aes_cbc_pkg::ISBOX[w_b[4*((c-r+4)%4)+r]]
                                   : aes_cbc_pkg::SBOX[w_b[4*((c+r)%4)+r]];
            end
        end
        for (int i = 0; i < 16; i++) begin
            w_sh[127-8*i -: 8] = w_s[i];
        end
        for (int c = 0; c < 4; c++) begin
            w_mx[127-32*c -: 32] = aes_cbc_pkg::mix_col(w_sh[127-32*c -: 32], 1'b0);
        end
        if (i_inv) begin
            w_mx = w_sh ^ i_rkey;
            if (i_mix) begin
                for (int c = 0; c < 4; c++) begin
                    w_mx[127-32*c -: 32] = aes_cbc_pkg::mix_col(w_mx[127-32*c -: 32], 1'b1);
                end
            end
            o_state = w_mx;
        end else begin
            o_state = (i_mix ? w_mx : w_sh) ^ i_rkey;
        end
    end
endmodule

// ----- rtl/core/aes128_cbc_pkcs7_cipher.sv -----
// Top level: AES-128 CBC cipher with PKCS#7 padding, APB register port.
// An accepted block passes load, ten rounds and finish before its result is valid.
// A new block is accepted only in idle, once the last result is taken; a full final
// encrypt block gives a second, all-padding result after the first result is taken.
// After a key write, the next block first runs key expansion into the round-key RAM.
// Reset: synchronous active low; control and registers clear, round keys marked stale.
module aes128_cbc_pkcs7_cipher (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [5:0]               paddr,
    input  logic [63:0]              pwdata,
    output logic [63:0]              prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  aes_cbc_pkg::t_in_item    i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output aes_cbc_pkg::t_out_item   o_data
);
    logic [63:0] r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic        r_dir, r_keys_ready, r_started;
    logic [127:0] r_chain, r_state, r_in, r_res;
    logic        r_fin, r_extra, r_opdir;
    logic [3:0]  r_round;
    logic [5:0]  r_kidx;
    logic [31:0] r_w1, r_w2, r_w3, r_w4;
    aes_cbc_pkg::t_state r_st, n_st;
    aes_cbc_pkg::t_out_item r_out, n_out;
    logic        r_ovalid;

    logic        w_wr;
    logic [2:0]  w_reg;
    logic        w_we;
    logic [31:0] w_wdata, w_t;
    logic [127:0] w_rkey, w_rnd;
    logic        w_inv;
    logic        w_rd_inv;
    logic [1:0]  w_q;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign w_reg = paddr[5:3];

    always_comb begin
        unique case (w_reg)
            aes_cbc_pkg::REG_KEY_HIGH:  prdata = r_key_hi;
            aes_cbc_pkg::REG_KEY_LOW:   prdata = r_key_lo;
            aes_cbc_pkg::REG_IV_HIGH:   prdata = r_iv_hi;
            aes_cbc_pkg::REG_IV_LOW:    prdata = r_iv_lo;
            aes_cbc_pkg::REG_DIRECTION: prdata = {63'd0, r_dir};
            default:                    prdata = 64'd0;
        endcase
    end

    // key expansion: words 0..43 written one a cycle; w[i-1..i-4] kept in r_w1..r_w4
    always_comb begin
        w_t = r_w1;
        if (r_kidx[1:0] == 2'd0) begin
            w_t = {aes_cbc_pkg::SBOX[r_w1[23:16]], aes_cbc_pkg::SBOX[r_w1[15:8]],
                   aes_cbc_pkg::SBOX[r_w1[7:0]], aes_cbc_pkg::SBOX[r_w1[31:24]]}
                  ^ {aes_cbc_pkg::RCON[4'(r_kidx[5:2] - 4'd1)], 24'd0};
        end
        unique case (r_kidx)
            6'd0:    w_wdata = r_key_hi[63:32];
            6'd1:    w_wdata = r_key_hi[31:0];
            6'd2:    w_wdata = r_key_lo[63:32];
            6'd3:    w_wdata = r_key_lo[31:0];
            default: w_wdata = r_w4 ^ w_t;
        endcase
    end

    // hold round keys as four RAM banks, one word each, addressed by round
    logic [31:0] w_bank_rd [4];
    logic [3:0]  w_rd_round;
    assign w_we = (r_st == aes_cbc_pkg::ST_KEYEXP)
                  && (r_kidx != 6'(aes_cbc_pkg::NumKeyWords));
    assign w_q = r_kidx[1:0];

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_bank
            aes_cbc_ram #(.Width(32), .Depth(11)) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_we && (w_q == 2'(g))),
                .i_waddr (r_kidx[5:2]),
                .i_wdata (w_wdata),
                .i_raddr (w_rd_round),
                .o_rdata (w_bank_rd[g])
            );
        end
    endgenerate
    assign w_rkey = {w_bank_rd[0], w_bank_rd[1], w_bank_rd[2], w_bank_rd[3]};

    assign w_inv = r_opdir;
    assign w_rd_inv = (r_st == aes_cbc_pkg::ST_IDLE && !r_extra) ? r_dir : r_opdir;

    // round numbering: forward reads key k=r_round; inverse reads key 10-r_round
    logic [3:0] n_round;
    always_comb begin
        n_round = r_round;
        if (r_st == aes_cbc_pkg::ST_LOAD || r_st == aes_cbc_pkg::ST_ROUND) begin
            n_round = r_round + 4'd1;
        end else begin
            n_round = 4'd0;
        end
        w_rd_round = w_rd_inv ? 4'(4'd10 - n_round) : n_round;
    end

    aes_cbc_round u_round (
        .i_state (r_state),
        .i_rkey  (w_rkey),
        .i_inv   (w_inv),
        .i_mix   (r_round != 4'd10),
        .o_state (w_rnd)
    );

    assign o_ready = (r_st == aes_cbc_pkg::ST_IDLE) && !r_ovalid && !r_extra;

    // input block, PKCS#7-padded when a short final block is encrypted
    logic [127:0] w_pin;
    logic [4:0]   w_v;
    always_comb begin
        w_v = (i_data.valid_bytes > 5'd16) ? 5'd16 : i_data.valid_bytes;
        w_pin = {i_data.block_high, i_data.block_low};
        if (!r_dir && i_data.final_block && w_v < 5'd16) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) >= w_v) begin
                    w_pin[127-8*i -: 8] = 8'(5'd16 - w_v);
                end
            end
        end
    end

    // padding check on the registered decrypt result
    logic [127:0] w_d2, w_strip2;
    logic [7:0]   w_pad2;
    logic         w_bad2;
    always_comb begin
        w_d2 = r_res ^ r_chain;
        w_pad2 = w_d2[7:0];
        w_bad2 = (w_pad2 == 8'd0) || (w_pad2 > 8'd16);
        w_strip2 = w_d2;
        for (int i = 0; i < 16; i++) begin
            if (!w_bad2 && (5'(i) >= 5'(5'd16 - w_pad2[4:0]))) begin
                if (w_d2[127-8*i -: 8] != w_pad2) begin
                    w_bad2 = 1'b1;
                end
                w_strip2[127-8*i -: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        n_out.status = 1'b0;
        n_out.out_bytes = 5'd16;
        n_out.out_last = r_fin && !r_extra;
        {n_out.out_high, n_out.out_low} = r_res;
        if (r_opdir) begin
            {n_out.out_high, n_out.out_low} = w_d2;
            if (r_fin) begin
                if (w_bad2) begin
                    n_out.status = 1'b1;
                    n_out.out_bytes = 5'd0;
                    {n_out.out_high, n_out.out_low} = '0;
                end else begin
                    n_out.out_bytes = 5'(5'd16 - w_pad2[4:0]);
                    {n_out.out_high, n_out.out_low} = w_strip2;
                end
            end
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            aes_cbc_pkg::ST_IDLE: begin
                if ((i_valid && o_ready) || (r_extra && !r_ovalid)) begin
                    n_st = r_keys_ready ? aes_cbc_pkg::ST_LOAD : aes_cbc_pkg::ST_KEYEXP;
                end
            end
            aes_cbc_pkg::ST_KEYEXP:
                if (r_kidx == 6'(aes_cbc_pkg::NumKeyWords)) n_st = aes_cbc_pkg::ST_LOAD;
            aes_cbc_pkg::ST_LOAD:   n_st = aes_cbc_pkg::ST_ROUND;
            aes_cbc_pkg::ST_ROUND:
                if (r_round == 4'(aes_cbc_pkg::NumRounds)) n_st = aes_cbc_pkg::ST_FINISH;
            aes_cbc_pkg::ST_FINISH: n_st = aes_cbc_pkg::ST_OUT;
            aes_cbc_pkg::ST_OUT:    n_st = aes_cbc_pkg::ST_IDLE;
            default:                n_st = aes_cbc_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= aes_cbc_pkg::ST_IDLE;
            r_key_hi <= '0; r_key_lo <= '0; r_iv_hi <= '0; r_iv_lo <= '0;
            r_dir <= 1'b0; r_keys_ready <= 1'b0; r_started <= 1'b0;
            r_ovalid <= 1'b0; r_extra <= 1'b0; r_kidx <= '0; r_round <= '0;
        end else begin
            r_st <= n_st;
            r_round <= n_round;
            if (w_wr) begin
                unique case (w_reg)
                    aes_cbc_pkg::REG_KEY_HIGH:  begin r_key_hi <= pwdata; r_keys_ready <= 1'b0; end
                    aes_cbc_pkg::REG_KEY_LOW:   begin r_key_lo <= pwdata; r_keys_ready <= 1'b0; end
                    aes_cbc_pkg::REG_IV_HIGH:   r_iv_hi <= pwdata;
                    aes_cbc_pkg::REG_IV_LOW:    r_iv_lo <= pwdata;
                    aes_cbc_pkg::REG_DIRECTION: r_dir <= pwdata[0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                aes_cbc_pkg::ST_IDLE: begin
                    r_kidx <= '0;
                    if (i_valid && o_ready) begin
                        r_opdir <= r_dir;
                        r_fin <= i_data.final_block;
                        r_in <= {i_data.block_high, i_data.block_low};
                        r_started <= !i_data.final_block;
                        r_extra <= !r_dir && i_data.final_block && (w_v == 5'd16);
                        if (!r_started) begin
                            r_chain <= {r_iv_hi, r_iv_lo};
                            r_state <= w_pin ^ (r_dir ? 128'd0 : {r_iv_hi, r_iv_lo});
                        end else begin
                            r_state <= w_pin ^ (r_dir ? 128'd0 : r_chain);
                        end
                    end else if (r_extra && !r_ovalid) begin
                        r_extra <= 1'b0;
                        r_fin <= 1'b1;
                        r_state <= {16{8'h10}} ^ r_chain;
                    end
                end
                aes_cbc_pkg::ST_KEYEXP: begin
                    r_w4 <= r_w3; r_w3 <= r_w2; r_w2 <= r_w1; r_w1 <= w_wdata;
                    r_kidx <= r_kidx + 6'd1;
                    if (r_kidx == 6'(aes_cbc_pkg::NumKeyWords - 1)) r_keys_ready <= 1'b1;
                end
                aes_cbc_pkg::ST_LOAD: begin
                    r_state <= r_state ^ w_rkey;
                end
                aes_cbc_pkg::ST_ROUND: begin
                    r_state <= w_rnd;
                    if (r_round == 4'(aes_cbc_pkg::NumRounds)) begin
                        r_res <= w_rnd;
                    end
                end
                aes_cbc_pkg::ST_FINISH: begin
                    r_ovalid <= 1'b1;
                    r_out <= n_out;
                    r_chain <= r_opdir ? r_in : r_res;
                end
                default: ;
            endcase
        end
    end
endmodule
